// File: src/obct_pkg.sv
`timescale 1ns / 1ps

package obct_pkg;

    localparam int COORD_BITS     = 11;
    localparam int ANGLE_BITS     = 10;
    localparam int TRIG_FRAC_BITS = 14;
    localparam int KEEP_BITS      = 8;

    localparam int QUARTER   = 1 << (ANGLE_BITS - 2);
    localparam int IDX_BITS  = ANGLE_BITS - 1;
    localparam int SINE_BITS = TRIG_FRAC_BITS + 1;
    localparam int TRIG_BITS = SINE_BITS + 1;
    localparam int TRIG_DROP = (TRIG_FRAC_BITS > KEEP_BITS) ? TRIG_FRAC_BITS - KEEP_BITS : 0;
    localparam int KEEP_FRAC = TRIG_FRAC_BITS - TRIG_DROP;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic [QUARTER:0][SINE_BITS-1:0] sine_tab_t;

    function automatic int rot_bits(input int coord_bits);
        return coord_bits + SINE_BITS + 5 - TRIG_DROP;
    endfunction

    function automatic logic [63:0] taylor_div(input logic [63:0] t, input int i);
        case (i)
            1:       return t / 64'd6;
            2:       return t / 64'd20;
            3:       return t / 64'd42;
            4:       return t / 64'd72;
            5:       return t / 64'd110;
            6:       return t / 64'd156;
            7:       return t / 64'd210;
            8:       return t / 64'd272;
            9:       return t / 64'd342;
            10:      return t / 64'd420;
            11:      return t / 64'd506;
            default: return t / 64'd600;
        endcase
    endfunction

    // quarter-wave sine, round(sin * 2^TRIG_FRAC_BITS), from a Q30 series
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t          tab;
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        for (int k = 0; k <= QUARTER; k++)
        begin
            x    = (64'(k) * (PI_Q30 * 64'd2)) >> ANGLE_BITS;
            term = x;
            sum  = signed'(x);
            for (int i = 1; i <= 12; i++)
            begin
                term = (term * x) >> 30;
                term = (term * x) >> 30;
                term = taylor_div(term, i);
                if ((i % 2) == 1)
                begin
                    sum = sum - signed'(term);
                end
                else
                begin
                    sum = sum + signed'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (unsigned'(sum) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
            if (v > (64'd1 << TRIG_FRAC_BITS))
            begin
                v = 64'd1 << TRIG_FRAC_BITS;
            end
            tab[k] = SINE_BITS'(v);
        end
        return tab;
    endfunction

endpackage

// File: src/obct_if.sv
`timescale 1ns / 1ps

interface obct_query_if #(
    parameter int COORD_BITS = obct_pkg::COORD_BITS
) ();
    logic                            valid;
    logic                            ready;
    logic [COORD_BITS-1:0]           box_x;
    logic [COORD_BITS-1:0]           box_y;
    logic [obct_pkg::ANGLE_BITS-1:0] box_angle;
    logic [COORD_BITS-1:0]           box_length;
    logic [COORD_BITS-1:0]           box_width;
    logic [COORD_BITS-1:0]           point_x;
    logic [COORD_BITS-1:0]           point_y;
    logic [COORD_BITS-1:0]           radius;

    modport source (
        output valid, box_x, box_y, box_angle, box_length, box_width,
               point_x, point_y, radius,
        input  ready
    );
    modport sink (
        input  valid, box_x, box_y, box_angle, box_length, box_width,
               point_x, point_y, radius,
        output ready
    );
endinterface

interface obct_result_if ();
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

// File: src/obct_rotate.sv
`timescale 1ns / 1ps

module obct_rotate #(
    parameter int COORD_BITS = obct_pkg::COORD_BITS
) (
    input  logic                                             clk,
    input  logic                                             adv,
    input  logic [COORD_BITS-1:0]                            box_x,
    input  logic [COORD_BITS-1:0]                            box_y,
    input  logic [obct_pkg::ANGLE_BITS-1:0]                  box_angle,
    input  logic [COORD_BITS-1:0]                            point_x,
    input  logic [COORD_BITS-1:0]                            point_y,
    output logic signed [obct_pkg::rot_bits(COORD_BITS)-1:0] rx,
    output logic signed [obct_pkg::rot_bits(COORD_BITS)-1:0] ry
);

    localparam int ANG      = obct_pkg::ANGLE_BITS;
    localparam int IDXB     = obct_pkg::IDX_BITS;
    localparam int SB       = obct_pkg::SINE_BITS;
    localparam int TB       = obct_pkg::TRIG_BITS;
    localparam int DROP     = obct_pkg::TRIG_DROP;
    localparam int D_BITS   = COORD_BITS + 2;
    localparam int P_BITS   = D_BITS + TB;
    localparam int SUM_BITS = P_BITS + 1;
    localparam int RND_BITS = SUM_BITS + 1;
    localparam int ROT_BITS = obct_pkg::rot_bits(COORD_BITS);
    localparam int HALF_INT = (DROP == 0) ? 0 : (1 << ((DROP == 0) ? 0 : DROP - 1));
    localparam logic signed [RND_BITS-1:0] RND_HALF = RND_BITS'(HALF_INT);

    localparam obct_pkg::sine_tab_t SINE_TAB = obct_pkg::build_sine_tab();

    function automatic logic signed [TB-1:0] trig(input logic [ANG-1:0] a);
        logic [1:0]      q;
        logic [IDXB-1:0] k;
        logic [IDXB-1:0] idx;
        logic [SB-1:0]   mag;
        q   = a[ANG-1:ANG-2];
        k   = {1'b0, a[ANG-3:0]};
        idx = q[0] ? (IDXB'(obct_pkg::QUARTER) - k) : k;
        mag = SINE_TAB[idx];
        return q[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    endfunction

    logic signed [D_BITS-1:0]   dx_reg, dy_reg;
    logic signed [TB-1:0]       sin_reg, cos_reg;
    logic signed [P_BITS-1:0]   xc_reg, ys_reg, yc_reg, xs_reg;
    logic signed [ROT_BITS-1:0] rx_reg, ry_reg;

    logic [D_BITS-1:0]          dx_next, dy_next;
    logic [ANG-1:0]             cos_angle;
    logic signed [SUM_BITS-1:0] sum_x, sum_y;
    logic signed [RND_BITS-1:0] rnd_x, rnd_y;

    always_comb
    begin
        dx_next   = ({2'b00, point_x} - {2'b00, box_x}) << 1;
        dy_next   = ({2'b00, point_y} - {2'b00, box_y}) << 1;
        cos_angle = box_angle + ANG'(obct_pkg::QUARTER);
        sum_x     = SUM_BITS'(xc_reg) + SUM_BITS'(ys_reg);
        sum_y     = SUM_BITS'(yc_reg) - SUM_BITS'(xs_reg);
        rnd_x     = RND_BITS'(sum_x) + RND_HALF;
        rnd_y     = RND_BITS'(sum_y) + RND_HALF;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg  <= signed'(dx_next);
            dy_reg  <= signed'(dy_next);
            sin_reg <= trig(box_angle);
            cos_reg <= trig(cos_angle);
            xc_reg  <= dx_reg * cos_reg;
            ys_reg  <= dy_reg * sin_reg;
            yc_reg  <= dy_reg * cos_reg;
            xs_reg  <= dx_reg * sin_reg;
            rx_reg  <= ROT_BITS'(rnd_x >>> DROP);
            ry_reg  <= ROT_BITS'(rnd_y >>> DROP);
        end
    end

    assign rx = rx_reg;
    assign ry = ry_reg;

endmodule

// File: src/oriented_box_circle_test.sv
`timescale 1ns / 1ps
// A result beat is offered once its query beat has passed through every register stage.
// Throughput: one query per cycle unless stalled; six register stages move together.
// Stages: trig lookup, four products, round, clamp, squares, compare.
// A stalled result beat holds every stage; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) empties the pipeline; no other state is kept.
module oriented_box_circle_test #(
    parameter int COORD_BITS = obct_pkg::COORD_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    obct_query_if.sink    query,
    obct_result_if.source result
);

    localparam int KEEP     = obct_pkg::KEEP_FRAC;
    localparam int ROT_BITS = obct_pkg::rot_bits(COORD_BITS);
    localparam int W_BITS   = ROT_BITS + 1;
    localparam int SQ_BITS  = 2 * ROT_BITS;
    localparam int D2_BITS  = SQ_BITS + 1;
    localparam int R2_BITS  = 2 * (COORD_BITS + 1) + 2 * KEEP;
    localparam int CMP_BITS = (D2_BITS > R2_BITS) ? D2_BITS : R2_BITS;
    localparam int STAGES   = 6;

    logic                       adv;
    logic [STAGES-1:0]          vld_reg;
    logic [COORD_BITS-1:0]      len_reg [0:2];
    logic [COORD_BITS-1:0]      wid_reg [0:2];
    logic [COORD_BITS-1:0]      rad_reg [0:3];
    logic signed [ROT_BITS-1:0] rx, ry;
    logic signed [ROT_BITS-1:0] ex_reg, ey_reg;
    logic [SQ_BITS-1:0]         ex2_reg, ey2_reg;
    logic [R2_BITS-1:0]         r2_reg;
    logic                       hit_reg;

    logic signed [W_BITS-1:0]   rx_w, ry_w, lim_x, lim_y;
    logic signed [W_BITS-1:0]   ex_next, ey_next;
    logic [COORD_BITS:0]        diam;
    logic [CMP_BITS-1:0]        d2, r2;

    assign adv         = !vld_reg[STAGES-1] || result.ready;
    assign query.ready = adv;

    obct_rotate #(
        .COORD_BITS (COORD_BITS)
    ) u_rotate (
        .clk       (clk),
        .adv       (adv),
        .box_x     (query.box_x),
        .box_y     (query.box_y),
        .box_angle (query.box_angle),
        .point_x   (query.point_x),
        .point_y   (query.point_y),
        .rx        (rx),
        .ry        (ry)
    );

    always_comb
    begin
        rx_w  = W_BITS'(rx);
        ry_w  = W_BITS'(ry);
        lim_x = signed'(W_BITS'({1'b0, len_reg[2]}) << KEEP);
        lim_y = signed'(W_BITS'({1'b0, wid_reg[2]}) << KEEP);
        if (rx_w > lim_x)
        begin
            ex_next = rx_w - lim_x;
        end
        else if (rx_w < -lim_x)
        begin
            ex_next = rx_w + lim_x;
        end
        else
        begin
            ex_next = '0;
        end
        if (ry_w > lim_y)
        begin
            ey_next = ry_w - lim_y;
        end
        else if (ry_w < -lim_y)
        begin
            ey_next = ry_w + lim_y;
        end
        else
        begin
            ey_next = '0;
        end
        diam = {rad_reg[3], 1'b0};
        d2   = CMP_BITS'(ex2_reg) + CMP_BITS'(ey2_reg);
        r2   = CMP_BITS'(r2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], query.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len_reg[0] <= query.box_length;
            wid_reg[0] <= query.box_width;
            rad_reg[0] <= query.radius;
            len_reg[1] <= len_reg[0];
            wid_reg[1] <= wid_reg[0];
            rad_reg[1] <= rad_reg[0];
            len_reg[2] <= len_reg[1];
            wid_reg[2] <= wid_reg[1];
            rad_reg[2] <= rad_reg[1];
            rad_reg[3] <= rad_reg[2];
            ex_reg     <= ROT_BITS'(ex_next);
            ey_reg     <= ROT_BITS'(ey_next);
            ex2_reg    <= SQ_BITS'(ex_reg * ex_reg);
            ey2_reg    <= SQ_BITS'(ey_reg * ey_reg);
            r2_reg     <= R2_BITS'(R2_BITS'(diam * diam) << (2 * KEEP));
            hit_reg    <= (d2 < r2);
        end
    end

    assign result.valid = vld_reg[STAGES-1];
    assign result.hit   = hit_reg;

endmodule

// File: src/obct_check.sv
`timescale 1ns / 1ps

module obct_check (
    input logic clk,
    input logic rst_n,
    input logic q_ready,
    input logic r_valid,
    input logic r_ready,
    input logic r_hit
);

    // a waiting result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> $stable(r_hit))
        else $error("hit changed while stalled");

    // an empty output stage never holds back the query side
    assert property (@(posedge clk) disable iff (!rst_n)
        !r_valid |-> q_ready)
        else $error("query refused with empty output");

    // taking a result frees the pipeline for a new query beat
    assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_ready |-> q_ready)
        else $error("query refused while result taken");

endmodule

bind oriented_box_circle_test obct_check u_obct_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_ready (query.ready),
    .r_valid (result.valid),
    .r_ready (result.ready),
    .r_hit   (result.hit)
);
